// ----- sv/ttgc_pkg.sv -----
// ----------------------------------------------------------------------------
// ttgc_pkg: shared types and constants of the gate classifier
// Gate kind codes, field widths, truth-table masking, hash and the
// classification result that travels from the classifier to the sequencer.
// ----------------------------------------------------------------------------
package ttgc_pkg;

    localparam int TRUTH_W    = 64;
    localparam int NIN_W      = 3;
    localparam int HASH_W     = 32;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 24;
    localparam int IDX_OUT_W  = 8;
    localparam int CNT_OUT_W  = 9;

    localparam logic [TRUTH_W-1:0] PARITY_PAT = 64'h6996_9669_9669_6996;

    typedef enum logic [3:0] {
        KIND_BUF    = 4'd0,
        KIND_NOT    = 4'd1,
        KIND_AND    = 4'd2,
        KIND_NAND   = 4'd3,
        KIND_OR     = 4'd4,
        KIND_NOR    = 4'd5,
        KIND_XOR    = 4'd6,
        KIND_XNOR   = 4'd7,
        KIND_STORED = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [NIN_W-1:0]     nin;
        logic [TRUTH_W-1:0]   truth;
        logic [HASH_W-1:0]    hash;
    } cls_t;

    // valid patterns of an n-input table
    function automatic logic [TRUTH_W-1:0] tt_mask(input logic [NIN_W-1:0] n);
        logic [TRUTH_W-1:0] m;
        begin
            case (n)
                3'd0:    m = 64'h0000_0000_0000_0001;
                3'd1:    m = 64'h0000_0000_0000_0003;
                3'd2:    m = 64'h0000_0000_0000_000F;
                3'd3:    m = 64'h0000_0000_0000_00FF;
                3'd4:    m = 64'h0000_0000_0000_FFFF;
                3'd5:    m = 64'h0000_0000_FFFF_FFFF;
                default: m = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    function automatic logic [HASH_W-1:0] tt_hash(input logic [TRUTH_W-1:0] t);
        logic [HASH_W-1:0] lo;
        logic [HASH_W-1:0] hi;
        begin
            lo = t[HASH_W-1:0];
            hi = t[TRUTH_W-1:HASH_W];
            return (lo | (lo >> 31)) ^ ((hi << 3) | (hi >> 28));
        end
    endfunction

endpackage

// ----- sv/truth_table_gate_classify_unique_core.sv -----
// ----------------------------------------------------------------------------
// truth_table_gate_classify_unique_core: gate classifier with unique table
// Names a Boolean function given as input count and truth table: a built-in
// gate kind, or the index of its entry in a hashed, chained function store.
// ----------------------------------------------------------------------------
// After reset the block clears each entry of the bucket-head memory with
// s_tready low. One beat is in flight at a time. A clear beat or a built-in
// gate goes straight on to load the result register. A stored function first
// passes the remainder unit that reduces the hash modulo BUCKETS by a
// reciprocal multiply; then the bucket head and its first entry are read, and
// the chain entries that pass the live check are compared in turn. On a miss
// the chain end is found and the function is inserted, or refused when the
// store is full; last the result register is loaded, and m_tvalid rises with
// it. A finished result waits in the output register while the next beat is
// accepted; a new result that finds it still full holds the block until it
// drains. A clear empties the store at once by resetting the fill count: heads
// and links that point at or above it, or at an entry of another bucket, are
// ignored.
// ----------------------------------------------------------------------------
module truth_table_gate_classify_unique_core #(
    parameter int CAPACITY   = 256,
    parameter int BUCKETS    = 1024,
    parameter int MAX_INPUTS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation [0], input_count [3:1], truth_table [67:4], zero fill
    input  logic [ttgc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // gate_kind [3:0], entry_index [11:4], is_new [12], table_full [13],
    // entry_count [22:14], zero fill
    output logic [ttgc_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int BAW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW  = $clog2(BUCKETS) + 1;

    typedef enum logic [6:0] {
        ST_SWEEP  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_HASH   = 7'b0000100,
        ST_LINK   = 7'b0001000,
        ST_CMP    = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [BAW-1:0]                  sweep_reg, sweep_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [ttgc_pkg::NIN_W-1:0]      nin_reg, nin_next;
    logic [ttgc_pkg::TRUTH_W-1:0]    truth_reg, truth_next;
    logic [BAW-1:0]                  bkt_reg, bkt_next;
    logic [IW-1:0]                   cur_reg, cur_next;
    logic                            cur_ok_reg, cur_ok_next;
    logic                            first_reg, first_next;
    logic [IW-1:0]                   link_reg, link_next;
    logic                            link_ok_reg, link_ok_next;
    ttgc_pkg::kind_t                 kind_reg, kind_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic                            new_reg, new_next;
    logic                            full_reg, full_next;
    logic                            m_valid_reg, m_valid_next;
    logic [ttgc_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;

    ttgc_pkg::cls_t                  cls;
    logic                            mod_start;
    logic                            mod_done;
    logic [RW-1:0]                   mod_rem;

    logic                            ent_we;
    logic                            ent_re;
    logic [IW-1:0]                   ent_raddr;
    logic [ttgc_pkg::TRUTH_W-1:0]    ent_qtruth;
    logic [ttgc_pkg::NIN_W-1:0]      ent_qnin;
    logic [IW-1:0]                   ent_qnext;
    logic                            ent_qhas;
    logic [BAW-1:0]                  ent_qbkt;
    logic                            head_we;
    logic [BAW-1:0]                  head_waddr;
    logic [IW-1:0]                   head_wdata;
    logic                            head_re;
    logic [IW-1:0]                   head_q;

    logic                            s_fire;
    logic                            live;
    logic                            out_free;

    ttgc_classify #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_classify (
        .nin_in   (s_tdata[3:1]),
        .truth_in (s_tdata[67:4]),
        .cls      (cls)
    );

    ttgc_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (cls.hash),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    ttgc_store #(
        .CAPACITY (CAPACITY),
        .BUCKETS  (BUCKETS)
    ) u_store (
        .aclk       (aclk),
        .ent_we     (ent_we),
        .ent_waddr  (IW'(count_reg)),
        .ent_wtruth (truth_reg),
        .ent_wnin   (nin_reg),
        .ent_wnext  (link_reg),
        .ent_whas   (link_ok_reg),
        .ent_wbkt   (bkt_reg),
        .ent_re     (ent_re),
        .ent_raddr  (ent_raddr),
        .ent_qtruth (ent_qtruth),
        .ent_qnin   (ent_qnin),
        .ent_qnext  (ent_qnext),
        .ent_qhas   (ent_qhas),
        .ent_qbkt   (ent_qbkt),
        .head_we    (head_we),
        .head_waddr (head_waddr),
        .head_wdata (head_wdata),
        .head_re    (head_re),
        .head_raddr (BAW'(mod_rem)),
        .head_q     (head_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // an entry counts only if it lies below the fill count and hashes here
    assign live = cur_ok_reg && (CW'(cur_reg) < count_reg) && (ent_qbkt == bkt_reg);

    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        count_next   = count_reg;
        nin_next     = nin_reg;
        truth_next   = truth_reg;
        bkt_next     = bkt_reg;
        cur_next     = cur_reg;
        cur_ok_next  = cur_ok_reg;
        first_next   = first_reg;
        link_next    = link_reg;
        link_ok_next = link_ok_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        new_next     = new_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        mod_start  = 1'b0;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_raddr  = ent_qnext;
        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = IW'(count_reg);
        head_re    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP: begin
                head_we    = 1'b1;
                head_waddr = sweep_reg;
                head_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == BAW'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    nin_next   = cls.nin;
                    truth_next = cls.truth;
                    kind_next  = cls.kind;
                    idx_next   = '0;
                    new_next   = 1'b0;
                    full_next  = 1'b0;
                    if (s_tdata[0]) begin
                        kind_next  = ttgc_pkg::KIND_BUF;
                        count_next = '0;
                        state_next = ST_DONE;
                    end else if (cls.kind != ttgc_pkg::KIND_STORED) begin
                        state_next = ST_DONE;
                    end else begin
                        mod_start  = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (mod_done) begin
                    head_re    = 1'b1;
                    bkt_next   = BAW'(mod_rem);
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                ent_re      = 1'b1;
                ent_raddr   = head_q;
                cur_next    = head_q;
                cur_ok_next = 1'b1;
                first_next  = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                first_next = 1'b0;
                if (first_reg) begin
                    link_next    = cur_reg;
                    link_ok_next = live;
                end
                if (live && ent_qnin == nin_reg && ent_qtruth == truth_reg) begin
                    idx_next   = cur_reg;
                    state_next = ST_DONE;
                end else if (live) begin
                    // follow the chain to the next older entry
                    ent_re      = 1'b1;
                    ent_raddr   = ent_qnext;
                    cur_next    = ent_qnext;
                    cur_ok_next = ent_qhas;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (count_reg >= CW'(CAPACITY)) begin
                    full_next = 1'b1;
                end else begin
                    ent_we     = 1'b1;
                    head_we    = 1'b1;
                    idx_next   = IW'(count_reg);
                    new_next   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[3:0]   = kind_reg;
                    m_data_next[11:4]  = full_reg ? '0 : ttgc_pkg::IDX_OUT_W'(idx_reg);
                    m_data_next[12]    = new_reg;
                    m_data_next[13]    = full_reg;
                    m_data_next[22:14] = ttgc_pkg::CNT_OUT_W'(count_reg);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            sweep_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        nin_reg     <= nin_next;
        truth_reg   <= truth_next;
        bkt_reg     <= bkt_next;
        cur_reg     <= cur_next;
        cur_ok_reg  <= cur_ok_next;
        first_reg   <= first_next;
        link_reg    <= link_next;
        link_ok_reg <= link_ok_next;
        kind_reg    <= kind_next;
        idx_reg     <= idx_next;
        new_reg     <= new_next;
        full_reg    <= full_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- sv/ttgc_classify.sv -----
// ----------------------------------------------------------------------------
// ttgc_classify: built-in gate recognition
// Clamps the input count, masks the table to its valid patterns, matches it
// against the built-in gate patterns in priority order and hashes it.
// ----------------------------------------------------------------------------
module ttgc_classify #(
    parameter int MAX_INPUTS = 6
) (
    input  logic [ttgc_pkg::NIN_W-1:0]   nin_in,
    input  logic [ttgc_pkg::TRUTH_W-1:0] truth_in,
    output ttgc_pkg::cls_t               cls
);

    logic [ttgc_pkg::NIN_W-1:0]   n;
    logic [ttgc_pkg::TRUTH_W-1:0] mask;
    logic [ttgc_pkg::TRUTH_W-1:0] t;
    logic [ttgc_pkg::TRUTH_W-1:0] and_pat;
    logic [ttgc_pkg::TRUTH_W-1:0] xor_pat;
    ttgc_pkg::kind_t              kind;

    always_comb begin
        n = (nin_in > ttgc_pkg::NIN_W'(MAX_INPUTS)) ? ttgc_pkg::NIN_W'(MAX_INPUTS) : nin_in;
        mask    = ttgc_pkg::tt_mask(n);
        t       = truth_in & mask;
        // only the all-ones pattern is set
        and_pat = mask & ~(mask >> 1);
        xor_pat = ttgc_pkg::PARITY_PAT & mask;

        if (n == 3'd1 && t == 64'd2) begin
            kind = ttgc_pkg::KIND_BUF;
        end else if (n == 3'd1 && t == 64'd1) begin
            kind = ttgc_pkg::KIND_NOT;
        end else if (t == and_pat) begin
            kind = ttgc_pkg::KIND_AND;
        end else if (t == (mask ^ and_pat)) begin
            kind = ttgc_pkg::KIND_NAND;
        end else if (t == (mask ^ 64'd1)) begin
            kind = ttgc_pkg::KIND_OR;
        end else if (t == 64'd1) begin
            kind = ttgc_pkg::KIND_NOR;
        end else if (t == xor_pat) begin
            kind = ttgc_pkg::KIND_XOR;
        end else if (t == (mask ^ xor_pat)) begin
            kind = ttgc_pkg::KIND_XNOR;
        end else begin
            kind = ttgc_pkg::KIND_STORED;
        end

        cls.kind  = kind;
        cls.nin   = n;
        cls.truth = t;
        cls.hash  = ttgc_pkg::tt_hash(t);
    end

endmodule

// ----- sv/ttgc_mod.sv -----
// ----------------------------------------------------------------------------
// ttgc_mod: bucket remainder unit
// Reduces the 32-bit hash modulo BUCKETS by a reciprocal multiply, a low-bit
// back-multiply and one compare-subtract, in that order; done pulses for
// one cycle with the remainder.
// ----------------------------------------------------------------------------
module ttgc_mod #(
    parameter int BUCKETS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ttgc_pkg::HASH_W-1:0]   value,
    output logic                          done,
    output logic [$clog2(BUCKETS):0]      rem
);

    localparam int RW  = $clog2(BUCKETS) + 1;
    localparam int HW  = ttgc_pkg::HASH_W;
    localparam int RCW = HW + 1;
    localparam int PW  = 2 * HW;
    // floor(2^32 / BUCKETS): the quotient estimate is short by at most one
    localparam logic [RCW-1:0] RECIP = RCW'((65'd1 << HW) / 65'(BUCKETS));

    logic                p1_reg, p1_next;
    logic                p2_reg, p2_next;
    logic                p3_reg, p3_next;
    logic                done_reg, done_next;
    logic [HW-1:0]       val_reg, val_next;
    logic [HW-1:0]       quo_reg, quo_next;
    logic [RW-1:0]       raw_reg, raw_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [PW-1:0]       prod;

    always_comb begin
        prod      = PW'(val_reg) * PW'(RECIP);

        p1_next   = start;
        p2_next   = p1_reg;
        p3_next   = p2_reg;
        done_next = p3_reg;

        val_next  = start ? value : val_reg;
        quo_next  = p1_reg ? prod[PW-1:HW] : quo_reg;
        // the remainder is below 2 * BUCKETS, so the low bits are enough
        raw_next  = p2_reg ? (val_reg[RW-1:0] - quo_reg[RW-1:0] * RW'(BUCKETS))
                           : raw_reg;
        rem_next  = rem_reg;
        if (p3_reg) begin
            rem_next = (raw_reg >= RW'(BUCKETS)) ? raw_reg - RW'(BUCKETS) : raw_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg   <= 1'b0;
            p2_reg   <= 1'b0;
            p3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
            done_reg <= done_next;
        end
        val_reg <= val_next;
        quo_reg <= quo_next;
        raw_reg <= raw_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- sv/ttgc_store.sv -----
// ----------------------------------------------------------------------------
// ttgc_store: entry and bucket-head memories
// Entry memory holds table, input count, chain link and bucket of each
// stored function; head memory holds the newest entry of each bucket.
// ----------------------------------------------------------------------------
module ttgc_store #(
    parameter int CAPACITY = 256,
    parameter int BUCKETS  = 1024
) (
    input  logic                                    aclk,
    input  logic                                    ent_we,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ent_waddr,
    input  logic [ttgc_pkg::TRUTH_W-1:0]            ent_wtruth,
    input  logic [ttgc_pkg::NIN_W-1:0]              ent_wnin,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ent_wnext,
    input  logic                                    ent_whas,
    input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0]   ent_wbkt,
    input  logic                                    ent_re,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ent_raddr,
    output logic [ttgc_pkg::TRUTH_W-1:0]            ent_qtruth,
    output logic [ttgc_pkg::NIN_W-1:0]              ent_qnin,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ent_qnext,
    output logic                                    ent_qhas,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0]   ent_qbkt,
    input  logic                                    head_we,
    input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0]   head_waddr,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] head_wdata,
    input  logic                                    head_re,
    input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0]   head_raddr,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] head_q
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BAW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    logic [ttgc_pkg::TRUTH_W-1:0] truth_mem [CAPACITY];
    logic [ttgc_pkg::NIN_W-1:0]   nin_mem   [CAPACITY];
    logic [IW-1:0]                next_mem  [CAPACITY];
    logic                         has_mem   [CAPACITY];
    logic [BAW-1:0]               bkt_mem   [CAPACITY];
    logic [IW-1:0]                head_mem  [BUCKETS];

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            truth_mem[ent_waddr] <= ent_wtruth;
            nin_mem[ent_waddr]   <= ent_wnin;
            next_mem[ent_waddr]  <= ent_wnext;
            has_mem[ent_waddr]   <= ent_whas;
            bkt_mem[ent_waddr]   <= ent_wbkt;
        end
        if (ent_re) begin
            ent_qtruth <= truth_mem[ent_raddr];
            ent_qnin   <= nin_mem[ent_raddr];
            ent_qnext  <= next_mem[ent_raddr];
            ent_qhas   <= has_mem[ent_raddr];
            ent_qbkt   <= bkt_mem[ent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re) begin
            head_q <= head_mem[head_raddr];
        end
    end

endmodule
